@@ design/ucs_pkg.sv @@
// ----------------------------------------------------------------------------
// ucs_pkg
// Shared types and constants of the URI component splitter: phase and status
// codes, component numbering, character constants and the string record that
// travels from the front end to the result drain.
// ----------------------------------------------------------------------------
package ucs_pkg;

   localparam int MAX_CHARS = 4096;
   localparam int POS_W     = $clog2(MAX_CHARS);
   localparam int NCOMP     = 8;
   localparam int COMP_W    = $clog2(NCOMP);
   localparam int RES_W     = 12;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_AT    = 8'h40;
   localparam logic [7:0] CH_QUEST = 8'h3F;
   localparam logic [7:0] CH_HASH  = 8'h23;

   localparam logic [1:0] REG_NO_AUTH  = 2'd0;
   localparam logic [1:0] REG_NO_QUERY = 2'd1;
   localparam logic [1:0] REG_NO_FRAG  = 2'd2;

   typedef enum logic [2:0] {
      PH_SCHEME = 3'd0,
      PH_SLASH1 = 3'd1,
      PH_SLASH2 = 3'd2,
      PH_AUTH   = 3'd3,
      PH_PATH   = 3'd4,
      PH_QUERY  = 3'd5,
      PH_FRAG   = 3'd6,
      PH_SKIP   = 3'd7
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_COLON = 2'd1,
      ST_NO_SLASH = 2'd2,
      ST_TOO_LONG = 2'd3
   } status_type;

   typedef enum logic [COMP_W-1:0] {
      C_SCHEME = 3'd0,
      C_USER   = 3'd1,
      C_PASS   = 3'd2,
      C_HOST   = 3'd3,
      C_PORT   = 3'd4,
      C_PATH   = 3'd5,
      C_QUERY  = 3'd6,
      C_FRAG   = 3'd7
   } comp_id_type;

   typedef struct packed {
      logic             present;
      logic [POS_W-1:0] start;
      logic [POS_W-1:0] len;
   } comp_type;

   typedef comp_type [NCOMP-1:0] comp_table_type;

   // One finished string: either an error code or the full component table.
   typedef struct packed {
      logic           is_err;
      status_type     code;
      comp_table_type comps;
   } record_type;

   typedef struct packed {
      logic no_auth;
      logic no_query;
      logic no_frag;
   } cfg_type;

endpackage

@@ design/ucs_front.sv @@
// ----------------------------------------------------------------------------
// ucs_front
// Character front end: tracks the parse phase, position and pending
// component boundaries, and hands a finished string record to the queue at
// the terminator.
// ----------------------------------------------------------------------------
module ucs_front
   import ucs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       chr_valid,
   output logic       chr_ready,
   input  logic [7:0] chr,
   output logic       push,
   output record_type push_rec,
   input  logic       q_full
);

   phase_type        phase_ff, phase_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] colon_off_ff, colon_off_in;
   logic             colon_seen_ff, colon_seen_in;
   logic [POS_W-1:0] seg_start_ff, seg_start_in;
   logic             user_found_ff, user_found_in;
   status_type       err_ff, err_in;
   comp_table_type   tbl_ff, tbl_in;

   logic accept;

   function automatic comp_type mk_comp(input logic [POS_W-1:0] s,
                                        input logic [POS_W-1:0] e);
      comp_type r;
      r.present = 1'b1;
      r.start   = s;
      r.len     = (e >= s) ? e - s : '0;
      return r;
   endfunction

   assign chr_ready = !q_full;
   assign accept    = chr_valid && chr_ready;

   always_comb begin
      comp_table_type   tbl_t;
      logic [POS_W-1:0] pos_p1;
      tbl_t         = tbl_ff;
      pos_p1        = pos_ff + 1'b1;
      phase_in      = phase_ff;
      pos_in        = pos_ff;
      colon_off_in  = colon_off_ff;
      colon_seen_in = colon_seen_ff;
      seg_start_in  = seg_start_ff;
      user_found_in = user_found_ff;
      err_in        = err_ff;
      push          = 1'b0;
      push_rec      = '0;

      if (accept) begin
         if (chr == CH_NUL) begin
            push = 1'b1;
            case (phase_ff)
               PH_SCHEME: begin
                  push_rec.is_err = 1'b1;
                  push_rec.code   = ST_NO_COLON;
               end
               PH_SLASH1, PH_SLASH2: begin
                  push_rec.is_err = 1'b1;
                  push_rec.code   = ST_NO_SLASH;
               end
               PH_AUTH: begin
                  if (colon_seen_ff) begin
                     tbl_t[C_HOST] = mk_comp(seg_start_ff, colon_off_ff);
                     tbl_t[C_PORT] = mk_comp(colon_off_ff + 1'b1, pos_ff);
                  end else begin
                     tbl_t[C_HOST] = mk_comp(seg_start_ff, pos_ff);
                  end
               end
               PH_PATH: tbl_t[C_PATH] = mk_comp(tbl_ff[C_PATH].start, pos_ff);
               PH_QUERY: tbl_t[C_QUERY] = mk_comp(tbl_ff[C_QUERY].start, pos_ff);
               PH_FRAG: tbl_t[C_FRAG] = mk_comp(tbl_ff[C_FRAG].start, pos_ff);
               default: begin
                  push_rec.is_err = 1'b1;
                  push_rec.code   = err_ff;
               end
            endcase
            if (!push_rec.is_err) begin
               push_rec.comps = tbl_t;
            end
            // Every per-string register returns to its reset value.
            phase_in      = PH_SCHEME;
            pos_in        = '0;
            colon_off_in  = '0;
            colon_seen_in = 1'b0;
            seg_start_in  = '0;
            user_found_in = 1'b0;
            err_in        = ST_OK;
            tbl_t         = '0;
         end else if (phase_ff != PH_SKIP) begin
            if (pos_ff >= POS_W'(MAX_CHARS - 1)) begin
               phase_in = PH_SKIP;
               err_in   = ST_TOO_LONG;
            end else begin
               case (phase_ff)
                  PH_SCHEME: begin
                     if (chr == CH_COLON) begin
                        tbl_t[C_SCHEME] = mk_comp('0, pos_ff);
                        phase_in        = PH_SLASH1;
                     end
                  end
                  PH_SLASH1: begin
                     if (chr == CH_SLASH) begin
                        phase_in = PH_SLASH2;
                     end else begin
                        phase_in = PH_SKIP;
                        err_in   = ST_NO_SLASH;
                     end
                  end
                  PH_SLASH2: begin
                     if (chr == CH_SLASH) begin
                        phase_in      = PH_AUTH;
                        seg_start_in  = pos_p1;
                        colon_seen_in = 1'b0;
                        user_found_in = 1'b0;
                     end else begin
                        phase_in = PH_SKIP;
                        err_in   = ST_NO_SLASH;
                     end
                  end
                  PH_AUTH: begin
                     if (!colon_seen_ff && chr == CH_COLON) begin
                        colon_seen_in = 1'b1;
                        colon_off_in  = pos_ff;
                     end else if (!cfg.no_auth && !user_found_ff && chr == CH_AT) begin
                        if (colon_seen_ff) begin
                           tbl_t[C_USER] = mk_comp(seg_start_ff, colon_off_ff);
                           tbl_t[C_PASS] = mk_comp(colon_off_ff + 1'b1, pos_ff);
                           colon_seen_in = 1'b0;
                        end else begin
                           tbl_t[C_USER] = mk_comp(seg_start_ff, pos_ff);
                        end
                        user_found_in = 1'b1;
                        seg_start_in  = pos_p1;
                     end else if (chr == CH_SLASH) begin
                        if (colon_seen_ff) begin
                           tbl_t[C_HOST] = mk_comp(seg_start_ff, colon_off_ff);
                           tbl_t[C_PORT] = mk_comp(colon_off_ff + 1'b1, pos_ff);
                        end else begin
                           tbl_t[C_HOST] = mk_comp(seg_start_ff, pos_ff);
                        end
                        tbl_t[C_PATH] = mk_comp(pos_ff, pos_ff);
                        phase_in      = PH_PATH;
                     end
                  end
                  PH_PATH: begin
                     if (!cfg.no_query && chr == CH_QUEST) begin
                        tbl_t[C_PATH]  = mk_comp(tbl_ff[C_PATH].start, pos_ff);
                        tbl_t[C_QUERY] = mk_comp(pos_p1, pos_p1);
                        phase_in       = PH_QUERY;
                     end else if (!cfg.no_frag && chr == CH_HASH) begin
                        tbl_t[C_PATH] = mk_comp(tbl_ff[C_PATH].start, pos_ff);
                        tbl_t[C_FRAG] = mk_comp(pos_p1, pos_p1);
                        phase_in      = PH_FRAG;
                     end
                  end
                  PH_QUERY: begin
                     if (!cfg.no_frag && chr == CH_HASH) begin
                        tbl_t[C_QUERY] = mk_comp(tbl_ff[C_QUERY].start, pos_ff);
                        tbl_t[C_FRAG]  = mk_comp(pos_p1, pos_p1);
                        phase_in       = PH_FRAG;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            if (phase_in != PH_SKIP) begin
               pos_in = pos_p1;
            end
         end
      end
      tbl_in = tbl_t;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SCHEME;
         pos_ff        <= '0;
         colon_off_ff  <= '0;
         colon_seen_ff <= 1'b0;
         seg_start_ff  <= '0;
         user_found_ff <= 1'b0;
         err_ff        <= ST_OK;
         tbl_ff        <= '0;
      end else begin
         phase_ff      <= phase_in;
         pos_ff        <= pos_in;
         colon_off_ff  <= colon_off_in;
         colon_seen_ff <= colon_seen_in;
         seg_start_ff  <= seg_start_in;
         user_found_ff <= user_found_in;
         err_ff        <= err_in;
         tbl_ff        <= tbl_in;
      end
   end

endmodule

@@ design/ucs_queue.sv @@
// ----------------------------------------------------------------------------
// ucs_queue
// Two-entry queue of finished string records between the front end and the
// result drain.
// ----------------------------------------------------------------------------
module ucs_queue
   import ucs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  record_type push_rec,
   output logic       full,
   input  logic       pop,
   output logic       head_valid,
   output record_type head_rec
);

   record_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_rec   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ design/ucs_back.sv @@
// ----------------------------------------------------------------------------
// ucs_back
// Result drain: walks the queue head record, one result per cycle unless
// rsp_ready stalls, in an output register: eight per string, one per error.
// ----------------------------------------------------------------------------
module ucs_back
   import ucs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  record_type       head_rec,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [2:0]       rsp_component,
   output logic             rsp_present,
   output logic [RES_W-1:0] rsp_start_res,
   output logic [RES_W-1:0] rsp_length,
   output logic             rsp_last
);

   logic [COMP_W-1:0] idx_ff, idx_in;
   logic              valid_ff, valid_in;
   logic [1:0]        status_ff, status_in;
   logic [2:0]        comp_ff, comp_in;
   logic              present_ff, present_in;
   logic [RES_W-1:0]  start_ff, start_in;
   logic [RES_W-1:0]  len_ff, len_in;
   logic              last_ff, last_in;
   logic              out_free;
   comp_type          cur;

   assign out_free = !valid_ff || rsp_ready;
   assign cur      = head_rec.comps[idx_ff];

   always_comb begin
      idx_in     = idx_ff;
      valid_in   = valid_ff;
      status_in  = status_ff;
      comp_in    = comp_ff;
      present_in = present_ff;
      start_in   = start_ff;
      len_in     = len_ff;
      last_in    = last_ff;
      pop        = 1'b0;
      if (out_free) begin
         valid_in = head_valid;
         if (head_valid) begin
            if (head_rec.is_err) begin
               status_in  = head_rec.code;
               comp_in    = C_SCHEME;
               present_in = 1'b0;
               start_in   = '0;
               len_in     = '0;
               last_in    = 1'b1;
               pop        = 1'b1;
               idx_in     = '0;
            end else begin
               status_in  = ST_OK;
               comp_in    = idx_ff;
               present_in = cur.present;
               start_in   = cur.present ? RES_W'(cur.start) : '0;
               len_in     = cur.present ? RES_W'(cur.len) : '0;
               last_in    = (idx_ff == COMP_W'(NCOMP - 1));
               pop        = last_in;
               idx_in     = idx_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      comp_ff    <= comp_in;
      present_ff <= present_in;
      start_ff   <= start_in;
      len_ff     <= len_in;
      last_ff    <= last_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_component = comp_ff;
   assign rsp_present   = present_ff;
   assign rsp_start_res = start_ff;
   assign rsp_length    = len_ff;
   assign rsp_last      = last_ff;

endmodule

@@ design/uri_component_splitter.sv @@
// ----------------------------------------------------------------------------
// uri_component_splitter
// Splits a NUL-terminated URI into scheme, user, password, host, port, path,
// query and fragment, reporting start offset and length of each.
// ----------------------------------------------------------------------------
// The block takes one character per cycle while the queue is not full. At the
// terminator the finished string moves as one record into a two-entry queue,
// and the result drain emits its eight results (or one error result) at one
// per cycle from an output register while the output is accepted. Characters
// therefore stream at one per cycle as long as strings average at least eight
// characters including the terminator; for shorter strings the drain sets the
// rate, and the request side stalls while both queue entries are occupied.
module uri_component_splitter
   import ucs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_ch,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [2:0]       rsp_component,
   output logic             rsp_present,
   output logic [RES_W-1:0] rsp_start_res,
   output logic [RES_W-1:0] rsp_length,
   output logic             rsp_last,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic             csr_wdata
);

   cfg_type    cfg_ff, cfg_in;
   logic       push, q_full, pop, head_valid;
   record_type push_rec, head_rec;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_NO_AUTH:  cfg_in.no_auth  = csr_wdata;
            REG_NO_QUERY: cfg_in.no_query = csr_wdata;
            REG_NO_FRAG:  cfg_in.no_frag  = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ucs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .chr_valid (req_valid),
      .chr_ready (req_ready),
      .chr       (req_ch),
      .push      (push),
      .push_rec  (push_rec),
      .q_full    (q_full)
   );

   ucs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_rec   (push_rec),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_rec   (head_rec)
   );

   ucs_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_rec      (head_rec),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_component (rsp_component),
      .rsp_present   (rsp_present),
      .rsp_start_res (rsp_start_res),
      .rsp_length    (rsp_length),
      .rsp_last      (rsp_last)
   );

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the URI component splitter. Characters are driven
// over the request channel, a behavioral copy of the splitter predicts the
// component spans of every terminated string, and each result is compared
// against the oldest pending prediction. A short table of hand-picked strings
// runs first, then random URIs under several flag settings and flow patterns.
// ----------------------------------------------------------------------------
module tb_top;
   import ucs_pkg::*;

   typedef struct packed {
      status_type       status;
      comp_id_type      comp;
      logic             present;
      logic [RES_W-1:0] start;
      logic [RES_W-1:0] len;
      logic             last;
   } span_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [7:0]       req_ch = 8'h00;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [1:0]       rsp_status;
   logic [2:0]       rsp_component;
   logic             rsp_present;
   logic [RES_W-1:0] rsp_start_res;
   logic [RES_W-1:0] rsp_length;
   logic             rsp_last;
   logic             csr_we = 1'b0;
   logic [1:0]       csr_index = 2'd0;
   logic             csr_wdata = 1'b0;

   uri_component_splitter i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_ch        (req_ch),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_component (rsp_component),
      .rsp_present   (rsp_present),
      .rsp_start_res (rsp_start_res),
      .rsp_length    (rsp_length),
      .rsp_last      (rsp_last),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Split predictor state.
   cfg_type    cur_cfg = '0;
   phase_type  uri_phase = PH_SCHEME;
   int         char_pos, colon_at, seg_from;
   bit         colon_found, user_done;
   status_type fail_code = ST_OK;
   bit         part_on [NCOMP];
   int         part_at [NCOMP];
   int         part_len [NCOMP];

   span_type   step_out [$];
   span_type   spans_due [$];
   logic [7:0] uri_text [$];

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int items_sent = 0;
   int mismatches = 0;
   bit hold_go = 0;
   int hold_left = 0;

   // Directed strings; a terminator is appended to each row.
   string      dir_text [4] = '{"", "a:", "h:/x", "\377://u:p@h:9/p?q#f"};
   bit         dir_typed [4] = '{1'b1, 1'b1, 1'b1, 1'b0};
   status_type dir_code [4] = '{ST_NO_COLON, ST_NO_SLASH, ST_NO_SLASH, ST_OK};

   cfg_type cfg_plan [6] = '{cfg_type'(3'b000), cfg_type'(3'b111), cfg_type'(3'b100),
                             cfg_type'(3'b010), cfg_type'(3'b001), cfg_type'(3'b011)};
   int      idle_send [4] = '{0, 71, 0, 27};
   int      idle_rsp [4] = '{0, 0, 71, 27};

   function automatic void clear_string();
      uri_phase   = PH_SCHEME;
      char_pos    = 0;
      colon_at    = 0;
      seg_from    = 0;
      colon_found = 0;
      user_done   = 0;
      fail_code   = ST_OK;
      for (int k = 0; k < NCOMP; k++) begin
         part_on[k]  = 0;
         part_at[k]  = 0;
         part_len[k] = 0;
      end
   endfunction

   function automatic void mark(comp_id_type k, int s, int e);
      part_on[k]  = 1;
      part_at[k]  = s;
      part_len[k] = (e >= s) ? e - s : 0;
   endfunction

   function automatic void close_host(int e);
      if (colon_found) begin
         mark(C_HOST, seg_from, colon_at);
         mark(C_PORT, colon_at + 1, e);
      end else begin
         mark(C_HOST, seg_from, e);
      end
   endfunction

   // The first error of a string wins.
   function automatic void abort_string(status_type code);
      if (uri_phase != PH_SKIP) begin
         fail_code = code;
         uri_phase = PH_SKIP;
      end
   endfunction

   function automatic void emit_error(status_type code);
      span_type s;
      s        = '0;
      s.status = code;
      s.last   = 1'b1;
      step_out.push_back(s);
   endfunction

   function automatic void emit_table();
      span_type s;
      for (int k = 0; k < NCOMP; k++) begin
         s.status  = ST_OK;
         s.comp    = comp_id_type'(k);
         s.present = part_on[k];
         s.start   = part_on[k] ? RES_W'(part_at[k]) : '0;
         s.len     = part_on[k] ? RES_W'(part_len[k]) : '0;
         s.last    = (k == NCOMP - 1);
         step_out.push_back(s);
      end
   endfunction

   function automatic void split_char(logic [7:0] c);
      int pos;
      comp_id_type k;
      step_out.delete();
      pos = char_pos;
      if (c == CH_NUL) begin
         case (uri_phase)
            PH_SCHEME: emit_error(ST_NO_COLON);
            PH_SLASH1, PH_SLASH2: emit_error(ST_NO_SLASH);
            PH_AUTH: begin
               close_host(pos);
               emit_table();
            end
            PH_PATH, PH_QUERY, PH_FRAG: begin
               k = (uri_phase == PH_PATH) ? C_PATH : (uri_phase == PH_QUERY) ? C_QUERY : C_FRAG;
               mark(k, part_at[k], pos);
               emit_table();
            end
            default: emit_error(fail_code);
         endcase
         clear_string();
         return;
      end
      if (uri_phase == PH_SKIP) return;
      if (pos >= MAX_CHARS - 1) begin
         abort_string(ST_TOO_LONG);
         return;
      end
      case (uri_phase)
         PH_SCHEME: begin
            if (c == CH_COLON) begin
               mark(C_SCHEME, 0, pos);
               uri_phase = PH_SLASH1;
            end
         end
         PH_SLASH1: begin
            if (c == CH_SLASH) uri_phase = PH_SLASH2;
            else abort_string(ST_NO_SLASH);
         end
         PH_SLASH2: begin
            if (c == CH_SLASH) begin
               uri_phase   = PH_AUTH;
               seg_from    = pos + 1;
               colon_found = 0;
               user_done   = 0;
            end else begin
               abort_string(ST_NO_SLASH);
            end
         end
         PH_AUTH: begin
            if (!colon_found && c == CH_COLON) begin
               colon_found = 1;
               colon_at    = pos;
            end else if (!cur_cfg.no_auth && !user_done && c == CH_AT) begin
               if (colon_found) begin
                  mark(C_USER, seg_from, colon_at);
                  mark(C_PASS, colon_at + 1, pos);
                  colon_found = 0;
               end else begin
                  mark(C_USER, seg_from, pos);
               end
               user_done = 1;
               seg_from  = pos + 1;
            end else if (c == CH_SLASH) begin
               close_host(pos);
               mark(C_PATH, pos, pos);
               uri_phase = PH_PATH;
            end
         end
         PH_PATH: begin
            if (!cur_cfg.no_query && c == CH_QUEST) begin
               mark(C_PATH, part_at[C_PATH], pos);
               mark(C_QUERY, pos + 1, pos + 1);
               uri_phase = PH_QUERY;
            end else if (!cur_cfg.no_frag && c == CH_HASH) begin
               mark(C_PATH, part_at[C_PATH], pos);
               mark(C_FRAG, pos + 1, pos + 1);
               uri_phase = PH_FRAG;
            end
         end
         PH_QUERY: begin
            if (!cur_cfg.no_frag && c == CH_HASH) begin
               mark(C_QUERY, part_at[C_QUERY], pos);
               mark(C_FRAG, pos + 1, pos + 1);
               uri_phase = PH_FRAG;
            end
         end
         default: ;
      endcase
      if (uri_phase != PH_SKIP) char_pos = pos + 1;
   endfunction

   // Mostly ordinary bytes, with the delimiters mixed in now and then.
   function automatic logic [7:0] text_char();
      logic [7:0] c;
      if ($urandom_range(99) < 15) begin
         case ($urandom_range(4))
            0: return CH_COLON;
            1: return CH_SLASH;
            2: return CH_AT;
            3: return CH_QUEST;
            default: return CH_HASH;
         endcase
      end
      do c = 8'($urandom_range(1, 255));
      while (c inside {CH_COLON, CH_SLASH, CH_AT, CH_QUEST, CH_HASH});
      return c;
   endfunction

   function automatic void add_chars(int n, bit letters);
      for (int i = 0; i < n; i++)
         uri_text.push_back(letters ? 8'($urandom_range(97, 122)) : text_char());
   endfunction

   function automatic void build_uri();
      int kind;
      kind = $urandom_range(99);
      uri_text.delete();
      if (kind < 80) begin
         add_chars($urandom_range(4), 1);
         uri_text.push_back(CH_COLON);
         uri_text.push_back(CH_SLASH);
         uri_text.push_back(CH_SLASH);
         if ($urandom_range(1)) begin
            add_chars($urandom_range(3), 0);
            if ($urandom_range(1)) begin
               uri_text.push_back(CH_COLON);
               add_chars($urandom_range(3), 0);
            end
            uri_text.push_back(CH_AT);
         end
         add_chars($urandom_range(4), 0);
         if ($urandom_range(1)) begin
            uri_text.push_back(CH_COLON);
            add_chars($urandom_range(3), 0);
         end
         if ($urandom_range(3) != 0) begin
            uri_text.push_back(CH_SLASH);
            add_chars($urandom_range(4), 0);
            if ($urandom_range(1)) begin
               uri_text.push_back(CH_QUEST);
               add_chars($urandom_range(3), 0);
            end
            if ($urandom_range(1)) begin
               uri_text.push_back(CH_HASH);
               add_chars($urandom_range(3), 0);
            end
         end
      end else if (kind < 92) begin
         // Scheme without its colon, or a colon followed by fewer than two slashes.
         add_chars($urandom_range(4), 1);
         if ($urandom_range(3) != 0) begin
            uri_text.push_back(CH_COLON);
            repeat ($urandom_range(1)) uri_text.push_back(CH_SLASH);
            add_chars($urandom_range(4), 0);
         end
      end else begin
         add_chars($urandom_range(8), 0);
      end
   endfunction

   task automatic send_char(logic [7:0] c, bit typed, status_type code);
      @(negedge clock);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_ch    <= c;
      do @(posedge clock);
      while (!req_ready);
      items_sent++;
      split_char(c);
      if (typed && c == CH_NUL) begin
         step_out.delete();
         emit_error(code);
      end
      foreach (step_out[i]) spans_due.push_back(step_out[i]);
   endtask

   task automatic send_text();
      foreach (uri_text[i]) send_char(uri_text[i], 1'b0, ST_OK);
      send_char(CH_NUL, 1'b0, ST_OK);
   endtask

   task automatic wait_drained(int settle);
      @(negedge clock);
      req_valid <= 1'b0;
      while (spans_due.size() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   task automatic write_cfg(cfg_type c);
      wait_drained(4);
      csr_we    <= 1'b1;
      csr_index <= REG_NO_AUTH;
      csr_wdata <= c.no_auth;
      @(negedge clock);
      csr_index <= REG_NO_QUERY;
      csr_wdata <= c.no_query;
      @(negedge clock);
      csr_index <= REG_NO_FRAG;
      csr_wdata <= c.no_frag;
      @(negedge clock);
      csr_we <= 1'b0;
      cur_cfg = c;
   endtask

   always @(negedge clock) begin
      if (hold_go) begin
         hold_left = 300;
         hold_go   = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (rsp_stall_pct != 0 && $urandom_range(99) < rsp_stall_pct) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic void flag_mismatch(string what, span_type want, span_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t %s: expected st=%0d comp=%0d pres=%0d start=%0d len=%0d last=%0d",
                  $time, what, want.status, want.comp, want.present, want.start, want.len,
                  want.last);
         $display("   got st=%0d comp=%0d pres=%0d start=%0d len=%0d last=%0d",
                  got.status, got.comp, got.present, got.start, got.len, got.last);
      end
   endfunction

   always @(posedge clock) begin
      span_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.status  = status_type'(rsp_status);
         got.comp    = comp_id_type'(rsp_component);
         got.present = rsp_present;
         got.start   = rsp_start_res;
         got.len     = rsp_length;
         got.last    = rsp_last;
         if (spans_due.size() == 0) begin
            flag_mismatch("result with nothing pending", '0, got);
         end else begin
            want = spans_due.pop_front();
            if (got.status != want.status || got.comp != want.comp ||
                got.present != want.present || got.start != want.start ||
                got.len != want.len || got.last != want.last)
               flag_mismatch("span mismatch", want, got);
         end
      end
   end

   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      int target;
      clear_string();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_text[r]) begin
         for (int i = 0; i < dir_text[r].len(); i++) send_char(dir_text[r][i], 1'b0, ST_OK);
         send_char(CH_NUL, dir_typed[r], dir_code[r]);
      end

      for (int p = 0; p < 6; p++) begin
         write_cfg(cfg_plan[p]);
         send_idle_pct = idle_send[p % 4];
         rsp_stall_pct = idle_rsp[p % 4];
         // Park the result side long enough for the string queue to fill up.
         if (p == 4) hold_go = 1;
         target = items_sent + 60;
         while (items_sent < target) begin
            build_uri();
            send_text();
         end
      end

      wait_drained(20);
      if (mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
